@@ rtl/jdhb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdhb_pkg
// Shared types and constants of the DHT segment parser and code builder.
// ----------------------------------------------------------------------------
package jdhb_pkg;

  localparam int unsigned MAX_CODE_BITS_DEF = 16;
  localparam int unsigned FIFO_DEPTH        = 4;
  localparam int unsigned NUM_LENGTHS       = 16;

  typedef enum logic [1:0] {
    KIND_CODE     = 2'd0,
    KIND_TABLE    = 2'd1,
    KIND_SEG_DONE = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_SHORT_LEN = 2'd0,
    ERR_CLASS_IDX = 2'd1,
    ERR_COUNTS    = 2'd2,
    ERR_OVERRUN   = 2'd3
  } err_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic        table_class;
    logic [1:0]  table_index;
    logic [15:0] code_value;
    logic [4:0]  code_length;
    logic [7:0]  symbol_value;
  } res_t;

  // up to two result words per input byte
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage
`default_nettype wire

@@ rtl/jdhb_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdhb_in_if
// Segment byte channel: valid/ready with one byte and a segment start flag.
// ----------------------------------------------------------------------------
interface jdhb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       segment_start;

  modport source (output valid, output data_byte, output segment_start, input ready);
  modport sink   (input valid, input data_byte, input segment_start, output ready);
endinterface
`default_nettype wire

@@ rtl/jdhb_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdhb_out_if
// Result channel: valid/ready with one code entry, status or error word.
// ----------------------------------------------------------------------------
interface jdhb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic        table_class;
  logic [1:0]  table_index;
  logic [15:0] code_value;
  logic [4:0]  code_length;
  logic [7:0]  symbol_value;

  modport source (
    output valid, output kind, output error_code, output table_class,
    output table_index, output code_value, output code_length,
    output symbol_value, input ready
  );
  modport sink (
    input valid, input kind, input error_code, input table_class,
    input table_index, input code_value, input code_length,
    input symbol_value, output ready
  );
endinterface
`default_nettype wire

@@ rtl/jpeg_dht_canonical_huffman_builder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_dht_canonical_huffman_builder
// Parses a define-Huffman-table segment and emits canonical code entries.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         words
//  in_i     in   data_byte, segment_start                        one per byte
//  out_o    out  kind, error_code, table_class, table_index,     0..2 per byte
//                code_value, code_length, symbol_value
//
//  one byte per cycle while in_i.ready is high; each byte is decoded in the
//  cycle it is taken and its result words go into a four-word output queue,
//  offered from the next cycle; in_i.ready is high while at most two words
//  are queued, so a stalled sink holds off input once three or four words
//  are waiting; length groups with no codes are skipped by a priority encoder
//  reset returns to idle; bytes before a segment start are dropped
// ----------------------------------------------------------------------------
module jpeg_dht_canonical_huffman_builder
  import jdhb_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  jdhb_in_if.sink    in_i,
  jdhb_out_if.source out_o
);

  push_t push;
  res_t  head;
  logic  room;
  logic  accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  jdhb_parser #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (in_i.data_byte),
    .segment_start_i (in_i.segment_start),
    .push_o          (push)
  );

  jdhb_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (head)
  );

  assign out_o.kind         = head.kind;
  assign out_o.error_code   = head.error_code;
  assign out_o.table_class  = head.table_class;
  assign out_o.table_index  = head.table_index;
  assign out_o.code_value   = head.code_value;
  assign out_o.code_length  = head.code_length;
  assign out_o.symbol_value = head.symbol_value;

endmodule
`default_nettype wire

@@ rtl/jdhb_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdhb_parser
// Segment FSM and canonical code assignment, one byte per accepted cycle.
// ----------------------------------------------------------------------------
module jdhb_parser
  import jdhb_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        accept_i,
  input  wire  [7:0] data_byte_i,
  input  wire        segment_start_i,
  output push_t      push_o
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_LEN_LO  = 5'b00010,
    PH_HEADER  = 5'b00100,
    PH_COUNTS  = 5'b01000,
    PH_SYMBOLS = 5'b10000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         len_hi_q, len_hi_d;
  logic signed [17:0] remain_q, remain_d;
  logic [4:0]         pos_q, pos_d;
  logic [7:0]         left_q, left_d;
  logic [16:0]        code_q, code_d;
  logic [2:0]         ci_q, ci_d;

  logic [7:0]             counts_q [NUM_LENGTHS];
  logic [NUM_LENGTHS-1:0] nz_q;
  logic                   cnt_wr;

  // shared group entry: priority encoder over nonzero counts
  logic [NUM_LENGTHS-1:0] nz_eff;
  logic [4:0]             grp_from;
  logic [3:0]             grp_base;
  logic [16:0]            grp_code;
  logic signed [17:0]     grp_remain;
  logic [3:0]             grp_j;
  logic                   grp_found;
  logic [7:0]             grp_cnt;
  res_t                   end_res;
  logic                   end_emit;
  phase_e                 end_phase;

  logic [15:0] len_full;
  logic [3:0]  sym_pos;
  logic [4:0]  sym_len;
  logic [16:0] code_inc;
  logic [7:0]  left_dec;
  logic        overflow;
  res_t        res0, res1;
  logic [1:0]  num;

  always_comb begin
    for (int i = 0; i < NUM_LENGTHS; i++) begin
      nz_eff[i] = (cnt_wr && pos_q[3:0] == 4'(i)) ? (data_byte_i != 8'd0) : nz_q[i];
    end
  end

  always_comb begin
    grp_j     = '0;
    grp_found = 1'b0;
    for (int i = NUM_LENGTHS - 1; i >= 0; i--) begin
      if (nz_eff[i] && 5'(i) >= grp_from) begin
        grp_j     = 4'(i);
        grp_found = 1'b1;
      end
    end
  end

  assign grp_cnt = (cnt_wr && grp_j == pos_q[3:0]) ? data_byte_i : counts_q[grp_j];

  // what follows the end of a table
  always_comb begin
    end_res  = '0;
    end_emit = 1'b1;
    if (grp_remain[17]) begin
      end_res.kind        = KIND_ERROR;
      end_res.error_code  = ERR_OVERRUN;
      end_res.table_class = ci_q[2];
      end_res.table_index = ci_q[1:0];
      end_phase           = PH_IDLE;
    end else if (grp_remain == '0) begin
      end_res.kind = KIND_SEG_DONE;
      end_phase    = PH_IDLE;
    end else begin
      end_emit  = 1'b0;
      end_phase = PH_HEADER;
    end
  end

  assign len_full = {len_hi_q, data_byte_i};
  assign sym_pos  = pos_q[3:0];
  assign sym_len  = {1'b0, sym_pos} + 5'd1;
  assign code_inc = code_q + 17'd1;
  assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
  assign overflow = ((code_inc >> sym_len) != 17'd0) || (sym_len > 5'(MAX_CODE_BITS));

  always_comb begin
    phase_d    = phase_q;
    len_hi_d   = len_hi_q;
    remain_d   = remain_q;
    pos_d      = pos_q;
    left_d     = left_q;
    code_d     = code_q;
    ci_d       = ci_q;
    cnt_wr     = 1'b0;
    res0       = '0;
    res1       = '0;
    num        = 2'd0;
    grp_from   = 5'd0;
    grp_base   = 4'd0;
    grp_code   = 17'd0;
    grp_remain = remain_q - 18'sd1;

    if (accept_i) begin
      if (segment_start_i) begin
        len_hi_d = data_byte_i;
        phase_d  = PH_LEN_LO;
      end else begin
        unique case (phase_q)
          PH_LEN_LO: begin
            if (len_full < 16'd2) begin
              res0.kind  = KIND_ERROR;
              res0.error_code = ERR_SHORT_LEN;
              num        = 2'd1;
              phase_d    = PH_IDLE;
            end else begin
              remain_d = $signed({2'b00, len_full}) - 18'sd2;
              if (len_full == 16'd2) begin
                res0.kind = KIND_SEG_DONE;
                num       = 2'd1;
                phase_d   = PH_IDLE;
              end else begin
                phase_d = PH_HEADER;
              end
            end
          end
          PH_HEADER: begin
            remain_d = remain_q - 18'sd1;
            if (data_byte_i[7:4] > 4'd1 || data_byte_i[3:0] > 4'd3) begin
              res0.kind       = KIND_ERROR;
              res0.error_code = ERR_CLASS_IDX;
              num             = 2'd1;
              phase_d         = PH_IDLE;
            end else begin
              ci_d             = {data_byte_i[4], data_byte_i[1:0]};
              pos_d            = 5'd0;
              phase_d          = PH_COUNTS;
              res0.kind        = KIND_TABLE;
              res0.table_class = data_byte_i[4];
              res0.table_index = data_byte_i[1:0];
              num              = 2'd1;
            end
          end
          PH_COUNTS: begin
            remain_d = remain_q - 18'sd1;
            cnt_wr   = 1'b1;
            pos_d    = pos_q + 5'd1;
            if (pos_q >= 5'(NUM_LENGTHS - 1)) begin
              grp_from = 5'd0;
              grp_base = 4'd0;
              grp_code = 17'd0;
              code_d   = 17'd0;
              if (grp_found) begin
                code_d  = grp_code << (grp_j - grp_base);
                pos_d   = {1'b0, grp_j};
                left_d  = grp_cnt;
                phase_d = PH_SYMBOLS;
              end else begin
                res0    = end_res;
                num     = {1'b0, end_emit};
                phase_d = end_phase;
              end
            end
          end
          PH_SYMBOLS: begin
            remain_d          = remain_q - 18'sd1;
            res0.kind         = KIND_CODE;
            res0.table_class  = ci_q[2];
            res0.table_index  = ci_q[1:0];
            res0.code_value   = code_q[15:0];
            res0.code_length  = sym_len;
            res0.symbol_value = data_byte_i;
            num               = 2'd1;
            code_d            = code_inc;
            left_d            = left_dec;
            if (left_dec == 8'd0) begin
              if (overflow) begin
                res1.kind        = KIND_ERROR;
                res1.error_code  = ERR_COUNTS;
                res1.table_class = ci_q[2];
                res1.table_index = ci_q[1:0];
                num              = 2'd2;
                phase_d          = PH_IDLE;
              end else begin
                grp_from = sym_len;
                grp_base = sym_pos;
                grp_code = code_inc;
                if (grp_found) begin
                  code_d  = grp_code << (grp_j - grp_base);
                  pos_d   = {1'b0, grp_j};
                  left_d  = grp_cnt;
                  phase_d = PH_SYMBOLS;
                end else begin
                  res1    = end_res;
                  num     = end_emit ? 2'd2 : 2'd1;
                  phase_d = end_phase;
                end
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign push_o.num  = num;
  assign push_o.res0 = res0;
  assign push_o.res1 = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      len_hi_q <= '0;
      remain_q <= '0;
      pos_q    <= '0;
      left_q   <= '0;
      code_q   <= '0;
      ci_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      remain_q <= remain_d;
      pos_q    <= pos_d;
      left_q   <= left_d;
      code_q   <= code_d;
      ci_q     <= ci_d;
    end
  end

  // count table, written once per table before any read
  always_ff @(posedge clk_i) begin
    if (cnt_wr) begin
      counts_q[pos_q[3:0]] <= data_byte_i;
      nz_q[pos_q[3:0]]     <= (data_byte_i != 8'd0);
    end
  end

endmodule
`default_nettype wire

@@ rtl/jdhb_res_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdhb_res_fifo
// Small result queue: takes up to two words a cycle, hands one out when ready.
// ----------------------------------------------------------------------------
module jdhb_res_fifo
  import jdhb_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output res_t       out_data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  res_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // space for a two-word burst
  assign room_o      = (cnt_q <= (PTR_W+1)'(FIFO_DEPTH - 2));
  assign out_data_o  = mem_q[rd_q];
  assign wr_next     = wr_q + PTR_W'(1);

  assign wr_d  = wr_q + PTR_W'(push_i.num);
  assign rd_d  = rd_q + PTR_W'(pop);
  assign cnt_d = cnt_q + (PTR_W+1)'(push_i.num) - (PTR_W+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

endmodule
`default_nettype wire

@@ verif/jpeg_dht_canonical_huffman_builder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jpeg_dht_canonical_huffman_builder_tb
// Feeds DHT segment bytes (well-formed tables, broken and aborted segments,
// stray bytes) through the byte channel and checks every result word against
// a canonical code predictor, under several patterns of source and sink idling.
// ----------------------------------------------------------------------------
module jpeg_dht_canonical_huffman_builder_tb;
  import jdhb_pkg::*;

  localparam int unsigned CODE_BITS = MAX_CODE_BITS_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 30;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 100;
  // error field reads zero for anything but an error word
  localparam err_e NO_ERR = ERR_SHORT_LEN;

  typedef enum logic [2:0] {
    PS_IDLE, PS_LEN_LO, PS_HEADER, PS_COUNTS, PS_SYMBOLS
  } parse_state_e;

  typedef enum int {
    SH_GOOD, SH_CHAIN, SH_CHAIN_OVF, SH_EMPTY, SH_OVERFLOW, SH_OVERRUN,
    SH_LONG, SH_BAD_HDR, SH_SHORT, SH_ABORT, SH_NOISE
  } seg_shape_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rx_hold = 1'b0;
  bit   pressure_phase = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   mismatch_count = 0;
  int   queued_items = 0;

  byte_item_t pending_bytes [$];
  res_t       expected_words [$];
  logic [7:0] seg_body [$];
  int         table_counts [16];

  // predictor state
  parse_state_e prs_state = PS_IDLE;
  logic [7:0]   len_msb = '0;
  int           seg_left = 0;
  logic [7:0]   code_counts [16];
  int           lens_seen = 0;
  int           group_left = 0;
  logic [16:0]  run_code = '0;
  logic [2:0]   tbl_sel = '0;

  jdhb_in_if  in_if ();
  jdhb_out_if out_if ();

  jpeg_dht_canonical_huffman_builder #(
    .MAX_CODE_BITS(CODE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_word(kind_e k, err_e e, logic [2:0] sel, logic [15:0] code,
                                    logic [4:0] len, logic [7:0] sym);
    res_t w;
    w.kind         = k;
    w.error_code   = e;
    w.table_class  = sel[2];
    w.table_index  = sel[1:0];
    w.code_value   = code;
    w.code_length  = len;
    w.symbol_value = sym;
    expected_words.push_back(w);
  endfunction

  task automatic close_table();
    if (seg_left < 0) begin
      push_word(KIND_ERROR, ERR_OVERRUN, tbl_sel, '0, '0, '0);
      prs_state = PS_IDLE;
    end else if (seg_left == 0) begin
      push_word(KIND_SEG_DONE, NO_ERR, '0, '0, '0, '0);
      prs_state = PS_IDLE;
    end else begin
      prs_state = PS_HEADER;
    end
  endtask

  // skip empty lengths, shifting the running code by the distance jumped
  task automatic open_group(input int first_len, input int prev_len);
    int j;
    j = first_len;
    while (j < 16 && code_counts[j] == 0) j++;
    if (j >= 16) begin
      close_table();
    end else begin
      run_code   = run_code << (j - prev_len);
      lens_seen  = j;
      group_left = int'(code_counts[j]);
      prs_state  = PS_SYMBOLS;
    end
  endtask

  task automatic parse_dht_byte(input logic [7:0] b, input logic seg_start);
    int         full_len;
    logic [4:0] code_len;
    if (seg_start) begin
      len_msb   = b;
      prs_state = PS_LEN_LO;
    end else begin
      case (prs_state)
        PS_LEN_LO: begin
          full_len = int'({len_msb, b});
          prs_state = PS_IDLE;
          if (full_len < 2) begin
            push_word(KIND_ERROR, ERR_SHORT_LEN, '0, '0, '0, '0);
          end else if (full_len == 2) begin
            push_word(KIND_SEG_DONE, NO_ERR, '0, '0, '0, '0);
          end else begin
            seg_left  = full_len - 2;
            prs_state = PS_HEADER;
          end
        end
        PS_HEADER: begin
          seg_left--;
          if (b[7:4] > 1 || b[3:0] > 3) begin
            push_word(KIND_ERROR, ERR_CLASS_IDX, '0, '0, '0, '0);
            prs_state = PS_IDLE;
          end else begin
            tbl_sel   = {b[4], b[1:0]};
            lens_seen = 0;
            prs_state = PS_COUNTS;
            push_word(KIND_TABLE, NO_ERR, tbl_sel, '0, '0, '0);
          end
        end
        PS_COUNTS: begin
          seg_left--;
          code_counts[lens_seen] = b;
          lens_seen++;
          if (lens_seen >= 16) begin
            run_code = '0;
            open_group(0, 0);
          end
        end
        PS_SYMBOLS: begin
          seg_left--;
          code_len = 5'(lens_seen + 1);
          push_word(KIND_CODE, NO_ERR, tbl_sel, run_code[15:0], code_len, b);
          run_code = run_code + 17'd1;
          if (group_left > 0) group_left--;
          if (group_left == 0) begin
            // group closed: the next code must still fit in this length
            if (int'(run_code) >= (1 << (lens_seen + 1)) || lens_seen + 1 > CODE_BITS) begin
              push_word(KIND_ERROR, ERR_COUNTS, tbl_sel, '0, '0, '0);
              prs_state = PS_IDLE;
            end else begin
              open_group(lens_seen + 1, lens_seen);
            end
          end
        end
        default: prs_state = PS_IDLE;
      endcase
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, wanted %0h", name, got, want));
  endtask

  task automatic check_word();
    res_t got;
    res_t want;
    got.kind         = out_if.kind;
    got.error_code   = out_if.error_code;
    got.table_class  = out_if.table_class;
    got.table_index  = out_if.table_index;
    got.code_value   = out_if.code_value;
    got.code_length  = out_if.code_length;
    got.symbol_value = out_if.symbol_value;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word of kind %0d with none outstanding", got.kind));
    end else begin
      want = expected_words.pop_front();
      check_field("kind", 16'(got.kind), 16'(want.kind));
      check_field("error_code", 16'(got.error_code), 16'(want.error_code));
      check_field("table_class", 16'(got.table_class), 16'(want.table_class));
      check_field("table_index", 16'(got.table_index), 16'(want.table_index));
      check_field("code_value", got.code_value, want.code_value);
      check_field("code_length", 16'(got.code_length), 16'(want.code_length));
      check_field("symbol_value", 16'(got.symbol_value), 16'(want.symbol_value));
    end
  endtask

  // ---------------------------------------------------------------- driver and monitor

  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    byte_item_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) parse_dht_byte(in_if.data_byte, in_if.segment_start);
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_if.valid         <= 1'b1;
          in_if.data_byte     <= nxt.data;
          in_if.segment_start <= nxt.start;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : word_monitor
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_word();
      out_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // long sink hold-off so the output queue fills and input backs up
  initial begin : sink_hold
    wait (pressure_phase);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_item(input logic [7:0] d, input logic s);
    byte_item_t it;
    it.data  = d;
    it.start = s;
    pending_bytes.push_back(it);
  endtask

  function automatic logic [7:0] good_hdr();
    logic [7:0] h;
    h      = '0;
    h[4]   = 1'($urandom_range(0, 1));
    h[1:0] = 2'($urandom_range(0, 3));
    return h;
  endfunction

  function automatic logic [7:0] bad_hdr();
    logic [7:0] h;
    do h = 8'($urandom_range(0, 255)); while (h[7:4] <= 1 && h[3:0] <= 3);
    return h;
  endfunction

  // counts that fit the code space; at bad_len the group overflows it
  task automatic build_counts(input int budget, input int bad_len);
    longint code_at;
    longint room;
    int     hi;
    int     l;
    code_at = 0;
    for (l = 1; l <= 16; l++) begin
      room = (longint'(1) << l) - code_at;
      if (l == bad_len) begin
        table_counts[l-1] = int'(room) + int'($urandom_range(0, 2));
      end else if (bad_len != 0 && l > bad_len) begin
        table_counts[l-1] = 0;
      end else begin
        hi = int'(room) - 1;
        if (hi > budget) hi = budget;
        if (hi > 255) hi = 255;
        table_counts[l-1] = (hi > 0 && $urandom_range(0, 2) == 0) ?
                            int'($urandom_range(1, hi)) : 0;
      end
      budget  -= table_counts[l-1];
      code_at  = (code_at + table_counts[l-1]) << 1;
    end
  endtask

  task automatic add_table(input logic [7:0] hdr, input bit pin_ends);
    int         l;
    int         s;
    int         total;
    logic [7:0] sym;
    total = 0;
    seg_body.push_back(hdr);
    for (l = 0; l < 16; l++) begin
      seg_body.push_back(8'(table_counts[l]));
      total += table_counts[l];
    end
    for (s = 0; s < total; s++) begin
      sym = 8'($urandom_range(0, 255));
      if (pin_ends && s == 0) sym = 8'h00;
      if (pin_ends && s == total - 1) sym = 8'hFF;
      seg_body.push_back(sym);
    end
  endtask

  task automatic add_good_table();
    build_counts(int'($urandom_range(0, 12)), 0);
    add_table(good_hdr(), 1'b0);
  endtask

  task automatic add_segment(input seg_shape_e shape);
    int decl;
    int n;
    int i;
    if (shape == SH_NOISE) begin
      repeat ($urandom_range(1, 3)) push_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      seg_body.delete();
      case (shape)
        SH_CHAIN, SH_CHAIN_OVF: begin
          // one code per length walks the code up to 16'hFFFE at sixteen bits
          for (i = 0; i < 16; i++) table_counts[i] = 1;
          if (shape == SH_CHAIN_OVF) table_counts[15] = 2;
          add_table(good_hdr(), 1'b1);
        end
        SH_EMPTY: begin
          for (i = 0; i < 16; i++) table_counts[i] = 0;
          add_table(good_hdr(), 1'b0);
          if ($urandom_range(0, 1)) add_good_table();
        end
        SH_OVERFLOW: begin
          if ($urandom_range(0, 1)) add_good_table();
          build_counts(int'($urandom_range(0, 3)), int'($urandom_range(1, 4)));
          add_table(good_hdr(), 1'b0);
        end
        SH_BAD_HDR: begin
          if ($urandom_range(0, 1)) add_good_table();
          seg_body.push_back(bad_hdr());
          repeat ($urandom_range(1, 3)) seg_body.push_back(8'($urandom_range(0, 255)));
        end
        SH_SHORT: ;
        default: repeat ($urandom_range(1, 3)) add_good_table();
      endcase
      decl = seg_body.size() + 2;
      case (shape)
        SH_SHORT:   decl = int'($urandom_range(0, 2));
        SH_LONG:    decl = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                           decl + int'($urandom_range(1, 4000));
        SH_OVERRUN: decl = decl - int'($urandom_range(1, 8));
        default: ;
      endcase
      n = seg_body.size() + 2;
      // cut short, the next segment start drops whatever is in flight
      if (shape == SH_ABORT) n = int'($urandom_range(1, n - 1));
      push_item(decl[15:8], 1'b1);
      if (n > 1) push_item(decl[7:0], 1'b0);
      for (i = 0; i < n - 2; i++) push_item(seg_body[i], 1'b0);
      queued_items += n;
    end
  endtask

  function automatic seg_shape_e pick_shape();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return SH_GOOD;
    if (r < 60) return SH_CHAIN;
    if (r < 63) return SH_CHAIN_OVF;
    if (r < 66) return SH_EMPTY;
    if (r < 74) return SH_OVERFLOW;
    if (r < 80) return SH_OVERRUN;
    if (r < 85) return SH_LONG;
    if (r < 89) return SH_BAD_HDR;
    if (r < 93) return SH_SHORT;
    if (r < 97) return SH_ABORT;
    return SH_NOISE;
  endfunction

  task automatic queue_directed();
    push_item(8'hA5, 1'b0);                               // stray byte while idle
    push_item(8'h00, 1'b1); push_item(8'h00, 1'b0);       // length zero
    push_item(8'h00, 1'b1); push_item(8'h01, 1'b0);       // length one
    push_item(8'h00, 1'b1); push_item(8'h02, 1'b0);       // empty segment
    push_item(8'hFF, 1'b1);                               // restart in the length
    push_item(8'h00, 1'b1); push_item(8'h15, 1'b0);
    push_item(8'h13, 1'b0);                               // table start, then dropped
    push_item(8'h00, 1'b1); push_item(8'h03, 1'b0);
    push_item(8'hF0, 1'b0);                               // class out of range
    push_item(8'hFF, 1'b0);                               // ignored after the error
    push_item(8'h00, 1'b1); push_item(8'h03, 1'b0);
    push_item(8'h04, 1'b0);                               // index out of range
  endtask

  task automatic queue_random(input int target);
    int from_count;
    from_count = queued_items;
    while (queued_items - from_count < target) add_segment(pick_shape());
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_if.valid || expected_words.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    queue_random(ITEMS_PER_PHASE);
    wait_drained();
  endtask

  initial begin : stimulus
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.segment_start = 1'b0;
    out_if.ready        = 1'b0;
    rst_ni              = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    queue_directed();
    wait_drained();

    // deep tables, an empty table, overrun and code overflow first, with no idling
    add_segment(SH_CHAIN);
    add_segment(SH_CHAIN_OVF);
    add_segment(SH_EMPTY);
    add_segment(SH_OVERRUN);
    add_segment(SH_OVERFLOW);
    run_phase(0, 0);
    run_phase(56, 0);
    run_phase(0, 56);
    run_phase(32, 32);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    queue_random(ITEMS_PER_PHASE);
    pressure_phase = 1'b1;
    wait_drained();

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
rtl/jdhb_pkg.sv
rtl/jdhb_in_if.sv
rtl/jdhb_out_if.sv
rtl/jdhb_parser.sv
rtl/jdhb_res_fifo.sv
rtl/jpeg_dht_canonical_huffman_builder.sv
verif/jpeg_dht_canonical_huffman_builder_tb.sv
